FILE: rtl/core/tesp_pkg.sv
// Package for the terminal escape sequence parser: phase and command codes, byte classes.
// No dependencies.
`default_nettype none
package tesp_pkg;
    typedef enum logic [3:0] {
        PH_GROUND, PH_ESC, PH_CSI, PH_PARAM, PH_SEMI, PH_LEAD_SEMI,
        PH_Q, PH_QPARAM, PH_HASH, PH_PAREN
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE, BK_SGR, BK_SGR_LAST
    } t_back_state;

    localparam logic [4:0] CMD_NONE      = 5'd0;
    localparam logic [4:0] CMD_DISPLAY   = 5'd1;
    localparam logic [4:0] CMD_REVINDEX  = 5'd2;
    localparam logic [4:0] CMD_INDEX     = 5'd3;
    localparam logic [4:0] CMD_NEXTLINE  = 5'd4;
    localparam logic [4:0] CMD_RESET     = 5'd5;
    localparam logic [4:0] CMD_ALIGN     = 5'd6;
    localparam logic [4:0] CMD_UP        = 5'd7;
    localparam logic [4:0] CMD_DOWN      = 5'd8;
    localparam logic [4:0] CMD_RIGHT     = 5'd9;
    localparam logic [4:0] CMD_LEFT      = 5'd10;
    localparam logic [4:0] CMD_POSITION  = 5'd11;
    localparam logic [4:0] CMD_ERASELINE = 5'd12;
    localparam logic [4:0] CMD_ERASESCR  = 5'd13;
    localparam logic [4:0] CMD_SCROLL    = 5'd14;
    localparam logic [4:0] CMD_ANSWER    = 5'd15;
    localparam logic [4:0] CMD_ATTRIB    = 5'd16;
    localparam logic [4:0] CMD_MODES     = 5'd17;

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [4:0] FG_RESET = 5'd7;

    // decoded word handed from front to back
    typedef struct packed {
        logic [4:0]  cmd;
        logic [15:0] first;
        logic [15:0] second;
        logic [7:0]  ch;
        logic        sgr;
        logic        mode_upd;
        logic        mode_set;
        logic [15:0] mode_num;
        logic        mode_hi;
    } t_op;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/tesp_front.sv
// Front end: byte classification, parse phase, parameter gathering; emits one op per byte.
// Depends on tesp_pkg. Parameter store is an internal memory read by the back end.
`default_nettype none
module tesp_front import tesp_pkg::*; #(
    parameter int MAX_PARAMS  = 16,
    parameter int PARAM_WIDTH = 16,
    parameter int IW = $clog2(MAX_PARAMS),
    parameter int CW = $clog2(MAX_PARAMS + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [7:0]             i_byte,
    output logic                        o_ready,
    output logic                        o_valid,
    output t_op                         o_op,
    output logic [CW-1:0]               o_count,
    input  wire logic                   i_take,
    input  wire logic [IW-1:0]          i_rd_idx,
    output logic [PARAM_WIDTH-1:0]      o_rd_data
);
    localparam logic [PARAM_WIDTH-1:0] PMAX = '1;
    localparam logic [CW-1:0] CMAX = CW'(MAX_PARAMS);

    t_phase r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic r_skip, n_skip;
    logic [PARAM_WIDTH-1:0] r_last, n_last;   // copy of the newest parameter
    logic [PARAM_WIDTH-1:0] r_p0, n_p0, r_p1, n_p1;
    logic [PARAM_WIDTH-1:0] mem [MAX_PARAMS];
    logic r_v;
    t_op r_op, n_op;
    logic [CW-1:0] r_ocount, n_ocount;

    logic busy;       // a stored op still waits on the back end
    logic acc;
    logic wr_en;
    logic [IW-1:0] wr_idx;
    logic [PARAM_WIDTH-1:0] wr_data;
    logic [3:0] dig;
    logic [PARAM_WIDTH+3:0] mul10;

    assign busy    = r_v && !i_take;
    assign o_ready = !busy;
    assign acc     = i_valid && o_ready;
    assign o_valid = r_v;
    assign o_op    = r_op;
    assign o_count = r_ocount;
    assign dig     = i_byte[3:0];
    assign mul10   = {4'd0, r_last} * (PARAM_WIDTH+4)'(10) + (PARAM_WIDTH+4)'(dig);

    always_comb begin
        t_op g;
        logic [PARAM_WIDTH-1:0] upd;
        g = '0;
        if (i_byte != ESC_BYTE) begin
            g.cmd = CMD_DISPLAY;
            g.ch  = i_byte;
        end
        upd = (mul10 > {4'd0, PMAX}) ? PMAX : mul10[PARAM_WIDTH-1:0];
        n_phase  = r_phase;
        n_count  = r_count;
        n_skip   = r_skip;
        n_last   = r_last;
        n_p0     = r_p0;
        n_p1     = r_p1;
        n_op     = '0;
        n_ocount = r_count;
        wr_en    = 1'b0;
        wr_idx   = r_count[IW-1:0];
        wr_data  = PARAM_WIDTH'(dig);
        case (r_phase)
            PH_ESC: begin
                n_phase = PH_GROUND;
                case (i_byte)
                    "[": begin
                        n_phase = PH_CSI;
                        n_count = '0;
                        n_skip  = 1'b0;
                    end
                    "(", ")": n_phase = PH_PAREN;
                    "#": n_phase = PH_HASH;
                    "I", "M": n_op.cmd = CMD_REVINDEX;
                    "D": n_op.cmd = CMD_INDEX;
                    "E": n_op.cmd = CMD_NEXTLINE;
                    "c": n_op.cmd = CMD_RESET;
                    ">", "=", "H", "F", "G", "7", "8": ;
                    default: begin
                        n_op = g;
                        if (i_byte == ESC_BYTE) n_phase = PH_ESC;
                    end
                endcase
            end
            PH_CSI: begin
                n_phase = PH_GROUND;
                if (is_digit(i_byte)) begin
                    wr_en   = 1'b1;
                    wr_idx  = '0;
                    n_count = CW'(1);
                    n_skip  = 1'b0;
                    n_last  = PARAM_WIDTH'(dig);
                    n_p0    = PARAM_WIDTH'(dig);
                    n_phase = PH_PARAM;
                end else begin
                    case (i_byte)
                        "A": begin n_op.cmd = CMD_UP;    n_op.first = 16'd1; end
                        "B": begin n_op.cmd = CMD_DOWN;  n_op.first = 16'd1; end
                        "C": begin n_op.cmd = CMD_RIGHT; n_op.first = 16'd1; end
                        "D": begin n_op.cmd = CMD_LEFT;  n_op.first = 16'd1; end
                        "H", "f": begin
                            n_op.cmd = CMD_POSITION;
                            n_op.first = 16'd1;
                            n_op.second = 16'd1;
                        end
                        "K": n_op.cmd = CMD_ERASELINE;
                        "J": n_op.cmd = CMD_ERASESCR;
                        "g": ;
                        "m": begin
                            wr_en    = 1'b1;
                            wr_idx   = '0;
                            wr_data  = '0;
                            n_count  = CW'(1);
                            n_ocount = CW'(1);
                            n_skip   = 1'b0;
                            n_op.cmd = CMD_ATTRIB;
                            n_op.sgr = 1'b1;
                        end
                        "?": n_phase = PH_Q;
                        ";": n_phase = PH_LEAD_SEMI;
                        default: begin
                            n_op = g;
                            if (i_byte == ESC_BYTE) n_phase = PH_ESC;
                        end
                    endcase
                end
            end
            PH_PARAM, PH_QPARAM: begin
                if (is_digit(i_byte)) begin
                    if (!r_skip) begin
                        wr_en   = 1'b1;
                        wr_idx  = IW'(r_count - CW'(1));
                        wr_data = upd;
                        n_last  = upd;
                        if (r_count == CW'(1)) n_p0 = upd;
                        if (r_count == CW'(2)) n_p1 = upd;
                    end
                end else if (r_phase == PH_PARAM && i_byte == ";") begin
                    n_phase = PH_SEMI;
                end else if (r_phase == PH_PARAM) begin
                    n_phase = PH_GROUND;
                    if (i_byte == "m") begin
                        n_op.cmd = CMD_ATTRIB;
                        n_op.sgr = 1'b1;
                    end else if (r_count == CW'(1) &&
                                 (i_byte == "A" || i_byte == "B" || i_byte == "C" ||
                                  i_byte == "D" || i_byte == "H" || i_byte == "f" ||
                                  i_byte == "K" || i_byte == "J" || i_byte == "c" ||
                                  i_byte == "g" || i_byte == "q")) begin
                        n_op.first = 16'(r_p0);
                        case (i_byte)
                            "A": n_op.cmd = CMD_UP;
                            "B": n_op.cmd = CMD_DOWN;
                            "C": n_op.cmd = CMD_RIGHT;
                            "D": n_op.cmd = CMD_LEFT;
                            "H", "f": begin
                                n_op.cmd = CMD_POSITION;
                                n_op.second = 16'd1;
                            end
                            "K": n_op.cmd = CMD_ERASELINE;
                            "J": n_op.cmd = CMD_ERASESCR;
                            "c": begin
                                n_op.cmd = CMD_ANSWER;
                                n_op.first = '0;
                                n_op.ch = "0";
                            end
                            default: n_op.first = '0;
                        endcase
                    end else if (r_count == CW'(2) &&
                                 (i_byte == "r" || i_byte == "H" || i_byte == "f" ||
                                  i_byte == "q" || i_byte == "y" || i_byte == "R")) begin
                        if (i_byte == "r" || i_byte == "H" || i_byte == "f") begin
                            n_op.cmd = (i_byte == "r") ? CMD_SCROLL : CMD_POSITION;
                            n_op.first = 16'(r_p0);
                            n_op.second = 16'(r_p1);
                        end
                    end else begin
                        n_op = g;
                        if (i_byte == ESC_BYTE) n_phase = PH_ESC;
                    end
                end else begin
                    n_phase = PH_GROUND;
                    if (i_byte == "h" || i_byte == "l") begin
                        n_op.cmd = CMD_MODES;
                        n_op.first = 16'(r_p0);
                        n_op.mode_upd = 1'b1;
                        n_op.mode_set = (i_byte == "h");
                        n_op.mode_num = 16'(r_p0);
                        n_op.mode_hi = (PARAM_WIDTH > 16) &&
                                       ((r_p0 >> 16) != '0);
                    end else if (i_byte != "c") begin
                        n_op = g;
                        if (i_byte == ESC_BYTE) n_phase = PH_ESC;
                    end
                end
            end
            PH_SEMI: begin
                if (is_digit(i_byte)) begin
                    n_phase = PH_PARAM;
                    if (r_count < CMAX) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                        n_skip  = 1'b0;
                        n_last  = PARAM_WIDTH'(dig);
                        if (r_count == CW'(1)) n_p1 = PARAM_WIDTH'(dig);
                    end else begin
                        n_skip = 1'b1;
                    end
                end else begin
                    n_op = g;
                    n_phase = (i_byte == ESC_BYTE) ? PH_ESC : PH_GROUND;
                end
            end
            PH_LEAD_SEMI: begin
                if (i_byte == "H" || i_byte == "f") begin
                    n_phase = PH_GROUND;
                    n_op.cmd = CMD_POSITION;
                    n_op.first = 16'd1;
                    n_op.second = 16'd1;
                end else begin
                    n_op = g;
                    n_phase = (i_byte == ESC_BYTE) ? PH_ESC : PH_GROUND;
                end
            end
            PH_Q: begin
                if (is_digit(i_byte)) begin
                    wr_en   = 1'b1;
                    wr_idx  = '0;
                    n_count = CW'(1);
                    n_skip  = 1'b0;
                    n_last  = PARAM_WIDTH'(dig);
                    n_p0    = PARAM_WIDTH'(dig);
                    n_phase = PH_QPARAM;
                end else begin
                    n_op = g;
                    n_phase = (i_byte == ESC_BYTE) ? PH_ESC : PH_GROUND;
                end
            end
            PH_HASH: begin
                n_phase = PH_GROUND;
                if (is_digit(i_byte)) begin
                    if (i_byte == "8") n_op.cmd = CMD_ALIGN;
                end else begin
                    n_op = g;
                    if (i_byte == ESC_BYTE) n_phase = PH_ESC;
                end
            end
            PH_PAREN: begin
                n_phase = PH_GROUND;
                if (!(i_byte == "A" || i_byte == "B" || i_byte == "0" ||
                      i_byte == "1" || i_byte == "2")) begin
                    n_op = g;
                    if (i_byte == ESC_BYTE) n_phase = PH_ESC;
                end
            end
            default: begin
                n_op = g;
                n_phase = (i_byte == ESC_BYTE) ? PH_ESC : PH_GROUND;
            end
        endcase
        if (n_op.sgr) n_ocount = (r_phase == PH_CSI) ? CW'(1) : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_GROUND;
            r_count <= '0;
            r_skip  <= 1'b0;
            r_v     <= 1'b0;
        end else begin
            if (acc) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_skip  <= n_skip;
            end
            if (acc) r_v <= 1'b1;
            else if (i_take) r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_last   <= n_last;
            r_p0     <= n_p0;
            r_p1     <= n_p1;
            r_op     <= n_op;
            r_ocount <= n_ocount;
        end
        if (acc && wr_en) mem[wr_idx] <= wr_data;
        o_rd_data <= mem[i_rd_idx];
    end
endmodule
`default_nettype wire

FILE: rtl/core/tesp_back.sv
// Back end: applies attribute parameters and mode changes, forms result words.
// Depends on tesp_pkg; reads the parameter store of tesp_front one entry at a time.
`default_nettype none
module tesp_back import tesp_pkg::*; #(
    parameter int MAX_PARAMS  = 16,
    parameter int PARAM_WIDTH = 16,
    parameter int IW = $clog2(MAX_PARAMS),
    parameter int CW = $clog2(MAX_PARAMS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_op                i_op,
    input  wire logic [CW-1:0]      i_count,
    output logic                    o_take,
    output logic [IW-1:0]           o_rd_idx,
    input  wire logic [PARAM_WIDTH-1:0] i_rd_data,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output logic [4:0]              o_command,
    output logic [15:0]             o_first_value,
    output logic [15:0]             o_second_value,
    output logic [7:0]              o_char_out,
    output logic [4:0]              o_fg_color,
    output logic [4:0]              o_bg_color,
    output logic                    o_underline_on,
    output logic                    o_cursor_keys_normal,
    output logic                    o_wrap_on,
    output logic                    o_origin_relative
);
    t_back_state r_st, n_st;
    logic [CW-1:0] r_k, n_k;
    logic [4:0] r_fg, n_fg, r_bg, n_bg;
    logic r_ul, n_ul, r_br, n_br;
    logic [2:0] r_mode, n_mode;
    logic r_ov, n_ov;
    logic [4:0] r_cmd, n_cmd;
    logic [15:0] r_a, n_a, r_b, n_b;
    logic [7:0] r_ch, n_ch;
    logic [PARAM_WIDTH-1:0] v;
    logic [4:0] off;

    assign o_empty = !r_ov;
    assign o_command = r_cmd;
    assign o_first_value = r_a;
    assign o_second_value = r_b;
    assign o_char_out = r_ch;
    assign o_fg_color = r_fg;
    assign o_bg_color = r_bg;
    assign o_underline_on = r_ul;
    assign o_cursor_keys_normal = r_mode[0];
    assign o_wrap_on = r_mode[1];
    assign o_origin_relative = r_mode[2];
    assign o_rd_idx = r_k[IW-1:0];
    assign v = i_rd_data;
    assign off = r_br ? 5'd8 : 5'd0;

    always_comb begin
        n_st = r_st; n_k = r_k;
        n_fg = r_fg; n_bg = r_bg; n_ul = r_ul; n_br = r_br; n_mode = r_mode;
        n_ov = r_ov && !i_pop;
        n_cmd = r_cmd; n_a = r_a; n_b = r_b; n_ch = r_ch;
        o_take = 1'b0;
        case (r_st)
            BK_IDLE: begin
                if (i_valid && !n_ov) begin
                    if (i_op.sgr) begin
                        n_st = BK_SGR;
                        n_k = '0;
                    end else begin
                        o_take = 1'b1;
                        n_ov = 1'b1;
                        n_cmd = i_op.cmd; n_a = i_op.first;
                        n_b = i_op.second; n_ch = i_op.ch;
                        if (i_op.mode_upd && !i_op.mode_hi) begin
                            if (i_op.mode_num == 16'd1) n_mode[0] = !i_op.mode_set;
                            if (i_op.mode_num == 16'd7) n_mode[1] = i_op.mode_set;
                            if (i_op.mode_num == 16'd6) n_mode[2] = i_op.mode_set;
                        end
                    end
                end
            end
            BK_SGR: begin
                // read address r_k is presented now; the registered data for entry r_k is used in BK_SGR_LAST
                n_st = BK_SGR_LAST;
            end
            BK_SGR_LAST: begin
                if (v == '0) begin
                    n_fg = FG_RESET; n_bg = '0; n_ul = 1'b0;
                end else if (v == PARAM_WIDTH'(1)) begin
                    if (r_fg <= 5'd7) n_fg = r_fg + 5'd8;
                    n_br = 1'b1;
                end else if (v == PARAM_WIDTH'(2)) begin
                    if (r_fg > 5'd7) n_fg = r_fg - 5'd8;
                    n_br = 1'b0;
                end else if (v == PARAM_WIDTH'(4)) begin
                    n_ul = 1'b1;
                end else if (v == PARAM_WIDTH'(7)) begin
                    n_fg = r_bg; n_bg = r_fg;
                end else if (v == PARAM_WIDTH'(8)) begin
                    n_fg = r_bg;
                end else if (v >= PARAM_WIDTH'(30) && v <= PARAM_WIDTH'(39)) begin
                    n_fg = 5'(v - PARAM_WIDTH'(30)) + off;
                end else if (v >= PARAM_WIDTH'(40) && v <= PARAM_WIDTH'(49)) begin
                    n_bg = 5'(v - PARAM_WIDTH'(40)) + off;
                end
                n_k = r_k + CW'(1);
                if (n_k >= i_count) begin
                    n_st = BK_IDLE;
                    o_take = 1'b1;
                    n_ov = 1'b1;
                    n_cmd = CMD_ATTRIB; n_a = '0; n_b = '0; n_ch = '0;
                end else begin
                    n_st = BK_SGR;
                end
            end
            default: n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE; r_k <= '0;
            r_fg <= FG_RESET; r_bg <= '0; r_ul <= 1'b0; r_br <= 1'b0;
            r_mode <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_k <= n_k;
            r_fg <= n_fg; r_bg <= n_bg; r_ul <= n_ul; r_br <= n_br;
            r_mode <= n_mode; r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_a <= n_a; r_b <= n_b; r_ch <= n_ch;
    end
endmodule
`default_nettype wire

FILE: rtl/core/terminal_escape_sequence_parser.sv
// Terminal escape sequence parser: front decoder, one-word op buffer, back executor.
// Front and back each register their output word. Attribute parameters are applied
// in the back end, read from the parameter store one at a time (BK_SGR, BK_SGR_LAST).
// One byte per cycle while words are popped promptly and no such read runs. Synchronous
// active-low reset returns to ground phase with colours 7/0 and all modes clear.
`default_nettype none
module terminal_escape_sequence_parser import tesp_pkg::*; #(
    parameter int MAX_PARAMS  = 16,
    parameter int PARAM_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [4:0]       o_command,
    output logic [15:0]      o_first_value,
    output logic [15:0]      o_second_value,
    output logic [7:0]       o_char_out,
    output logic [4:0]       o_fg_color,
    output logic [4:0]       o_bg_color,
    output logic             o_underline_on,
    output logic             o_cursor_keys_normal,
    output logic             o_wrap_on,
    output logic             o_origin_relative
);
    localparam int IW = $clog2(MAX_PARAMS);
    localparam int CW = $clog2(MAX_PARAMS + 1);

    logic f_ready, f_valid, take;
    t_op op;
    logic [CW-1:0] cnt;
    logic [IW-1:0] rd_idx;
    logic [PARAM_WIDTH-1:0] rd_data;

    assign full = !f_ready;

    tesp_front #(.MAX_PARAMS(MAX_PARAMS), .PARAM_WIDTH(PARAM_WIDTH), .IW(IW), .CW(CW)) u_front (
        .i_clk, .i_rst_n, .i_valid(push), .i_byte(i_rx_byte), .o_ready(f_ready),
        .o_valid(f_valid), .o_op(op), .o_count(cnt), .i_take(take),
        .i_rd_idx(rd_idx), .o_rd_data(rd_data)
    );

    tesp_back #(.MAX_PARAMS(MAX_PARAMS), .PARAM_WIDTH(PARAM_WIDTH), .IW(IW), .CW(CW)) u_back (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_op(op), .i_count(cnt), .o_take(take),
        .o_rd_idx(rd_idx), .i_rd_data(rd_data), .o_empty(empty), .i_pop(pop),
        .o_command, .o_first_value, .o_second_value, .o_char_out,
        .o_fg_color, .o_bg_color, .o_underline_on, .o_cursor_keys_normal,
        .o_wrap_on, .o_origin_relative
    );
endmodule
`default_nettype wire
